>>> rtl/thf512_pkg.sv
// Shared types, constant tables and helper functions for the Threefish-512 pipeline.
`default_nettype none

package thf512_pkg;

    localparam int NumWords  = 8;
    localparam int NumKeys   = 9;
    localparam int NumRounds = 72;
    localparam int LastSub   = 18;

    typedef logic [63:0]           word_t;
    typedef word_t [NumWords-1:0]  blk_t;
    typedef word_t [NumKeys-1:0]   key_t;

    // Payload carried from cell to cell
    typedef struct packed {
        logic  kind;
        logic  feed;
        word_t tw0;
        word_t tw1;
        blk_t  x;
        blk_t  p;
    } stage_t;

    localparam logic        KIND_ENC = 1'b0;
    localparam logic        KIND_DEC = 1'b1;
    localparam word_t       KS_PARITY = 64'h1BD11BDAA9FC1A22;

    localparam logic [5:0] ROT [8][4] = '{
        '{6'd46, 6'd36, 6'd19, 6'd37},
        '{6'd33, 6'd27, 6'd14, 6'd42},
        '{6'd17, 6'd49, 6'd36, 6'd39},
        '{6'd44, 6'd9,  6'd54, 6'd56},
        '{6'd39, 6'd30, 6'd34, 6'd24},
        '{6'd13, 6'd50, 6'd10, 6'd17},
        '{6'd25, 6'd29, 6'd39, 6'd43},
        '{6'd8,  6'd35, 6'd56, 6'd22}
    };

    localparam logic [2:0] PAIR [4][8] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd2, 3'd1, 3'd4, 3'd7, 3'd6, 3'd5, 3'd0, 3'd3},
        '{3'd4, 3'd1, 3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7},
        '{3'd6, 3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4, 3'd3}
    };

    // Rotations used here are never zero
    function automatic word_t rotl(word_t v, logic [5:0] n);
        return (v << n) | (v >> (7'd64 - {1'b0, n}));
    endfunction

    function automatic word_t rotr(word_t v, logic [5:0] n);
        return (v >> n) | (v << (7'd64 - {1'b0, n}));
    endfunction

    // Subkey s; km = s mod 9, tm = s mod 3
    function automatic blk_t subkey(key_t k, word_t t0, word_t t1,
                                    int s, int km, int tm);
        word_t t [3];
        blk_t  sk;
        int    idx;
        int    ta;
        int    tb;
        t[0] = t0;
        t[1] = t1;
        t[2] = t0 ^ t1;
        for (int i = 0; i < NumWords; i++) begin
            idx = km + i;
            if (idx >= NumKeys) idx = idx - NumKeys;
            sk[i] = k[idx];
        end
        ta = tm;
        tb = (tm == 2) ? 0 : tm + 1;
        sk[5] = sk[5] + t[ta];
        sk[6] = sk[6] + t[tb];
        sk[7] = sk[7] + word_t'(s);
        return sk;
    endfunction

endpackage

`default_nettype wire

>>> rtl/thf_cell.sv
// One pipeline cell: a forward round or its inverse, with subkey injection where due.
`default_nettype none

module thf_cell
    import thf512_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   vld_in,
    input  wire stage_t st_in,
    input  wire key_t   key,
    output logic        vld_out,
    output stage_t      st_out
);

    localparam int RE = IDX % 8;
    localparam int PE = IDX % 4;
    localparam int RD = (NumRounds - 1 - IDX) % 8;
    localparam int PD = (NumRounds - 1 - IDX) % 4;
    localparam int SE = (IDX + 1) / 4;
    localparam int SD = LastSub - SE;
    localparam bit HAS_SK = ((IDX % 4) == 3);

    logic   vld_reg;
    stage_t st_reg;
    stage_t st_next;

    always_comb
    begin
        blk_t       xe;
        blk_t       xd;
        blk_t       ske;
        blk_t       skd;
        logic [2:0] a;
        logic [2:0] b;
        xe = st_in.x;
        xd = st_in.x;
        for (int j = 0; j < 4; j++)
        begin
            a = PAIR[PE][2*j];
            b = PAIR[PE][2*j+1];
            xe[a] = xe[a] + xe[b];
            xe[b] = rotl(xe[b], ROT[RE][j]) ^ xe[a];
        end
        for (int j = 0; j < 4; j++)
        begin
            a = PAIR[PD][2*j];
            b = PAIR[PD][2*j+1];
            xd[b] = rotr(xd[a] ^ xd[b], ROT[RD][j]);
            xd[a] = xd[a] - xd[b];
        end
        ske = subkey(key, st_in.tw0, st_in.tw1, SE, SE % 9, SE % 3);
        skd = subkey(key, st_in.tw0, st_in.tw1, SD, SD % 9, SD % 3);
        if (HAS_SK)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                xe[i] = xe[i] + ske[i];
                xd[i] = xd[i] - skd[i];
            end
        end
        st_next   = st_in;
        st_next.x = (st_in.kind == KIND_DEC) ? xd : xe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

endmodule

`default_nettype wire

>>> rtl/threefish512_block_cipher.sv
// Top level of the Threefish-512 block cipher: key registers, entry stage, round chain, output.
// Path: entry stage register, 72 round cell registers, then the output register under done.
// Throughput: one block per cycle; busy is never raised, the chain of 72 round cells
// takes a new beat every cycle and each cell holds exactly one block in flight.
// Reset: rst_n clears all valid flags and key words; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle under done.
`default_nettype none

module threefish512_block_cipher
    import thf512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic        feed,
    input  wire logic [63:0] tweak_lo,
    input  wire logic [63:0] tweak_hi,
    input  wire logic [63:0] word0,
    input  wire logic [63:0] word1,
    input  wire logic [63:0] word2,
    input  wire logic [63:0] word3,
    input  wire logic [63:0] word4,
    input  wire logic [63:0] word5,
    input  wire logic [63:0] word6,
    input  wire logic [63:0] word7,
    // result side
    output logic             done,
    output logic      [63:0] out_word0,
    output logic      [63:0] out_word1,
    output logic      [63:0] out_word2,
    output logic      [63:0] out_word3,
    output logic      [63:0] out_word4,
    output logic      [63:0] out_word5,
    output logic      [63:0] out_word6,
    output logic      [63:0] out_word7
);

    // Key registers, eight words at byte addresses 8*i
    word_t key_reg [NumWords];
    key_t  key;
    word_t parity;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++)
                key_reg[i] <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            key_reg[paddr[5:3]] <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = key_reg[paddr[5:3]];

    // Ninth key word: parity of the eight with the schedule constant
    always_comb
    begin
        parity = KS_PARITY;
        for (int i = 0; i < NumWords; i++)
        begin
            key[i] = key_reg[i];
            parity = parity ^ key_reg[i];
        end
        key[NumWords] = parity;
    end

    // Never hold off a command: the chain advances every cycle
    assign busy = 1'b0;

    // Entry stage: inject subkey 0 on encryption, strip the last subkey on decryption
    stage_t st_in_next;
    stage_t chain [NumRounds+1];
    logic   vld   [NumRounds+1];
    logic   vld0_reg;
    stage_t st0_reg;

    always_comb
    begin
        blk_t blk;
        blk_t sk0;
        blk_t skl;
        blk = {word7, word6, word5, word4, word3, word2, word1, word0};
        sk0 = subkey(key, tweak_lo, tweak_hi, 0, 0, 0);
        skl = subkey(key, tweak_lo, tweak_hi, LastSub, LastSub % 9, LastSub % 3);
        st_in_next.kind = kind;
        st_in_next.feed = feed;
        st_in_next.tw0  = tweak_lo;
        st_in_next.tw1  = tweak_hi;
        st_in_next.p    = blk;
        for (int i = 0; i < NumWords; i++)
        begin
            st_in_next.x[i] = (kind == KIND_DEC) ? blk[i] - skl[i] : blk[i] + sk0[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else
            vld0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        st0_reg <= st_in_next;
    end

    assign vld[0]   = vld0_reg;
    assign chain[0] = st0_reg;

    // Round chain: cell i runs forward round i, or inverse round 71-i
    for (genvar g = 0; g < NumRounds; g++)
    begin : g_cell
        thf_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (vld[g]),
            .st_in   (chain[g]),
            .key     (key),
            .vld_out (vld[g+1]),
            .st_out  (chain[g+1])
        );
    end

    // Output stage: apply feed-forward on encryption only, then drop onto the ports
    logic done_reg;
    blk_t out_reg;
    blk_t out_next;

    always_comb
    begin
        for (int i = 0; i < NumWords; i++)
        begin
            if (chain[NumRounds].feed && chain[NumRounds].kind == KIND_ENC)
                out_next[i] = chain[NumRounds].x[i] ^ chain[NumRounds].p[i];
            else
                out_next[i] = chain[NumRounds].x[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld[NumRounds];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done      = done_reg;
    assign out_word0 = out_reg[0];
    assign out_word1 = out_reg[1];
    assign out_word2 = out_reg[2];
    assign out_word3 = out_reg[3];
    assign out_word4 = out_reg[4];
    assign out_word5 = out_reg[5];
    assign out_word6 = out_reg[6];
    assign out_word7 = out_reg[7];

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the Threefish-512 block cipher pipeline.
`default_nettype none

module testbench
    import thf512_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  Latency   = 74;
    localparam int  CycleCap  = 400000;
    localparam logic [5:0] AddrKey0 = 6'd0;

    typedef struct packed {
        logic  kind;
        logic  feed;
        word_t tw_lo;
        word_t tw_hi;
        blk_t  blk;
    } block_req_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        kind;
    logic        feed;
    logic [63:0] tweak_lo;
    logic [63:0] tweak_hi;
    logic [63:0] word0, word1, word2, word3, word4, word5, word6, word7;
    logic        done;
    logic [63:0] out_word0, out_word1, out_word2, out_word3;
    logic [63:0] out_word4, out_word5, out_word6, out_word7;

    // Key as the predictor sees it; updated together with every register write
    word_t       key_shadow [8];
    block_req_t  pending_blocks [$];
    blk_t        expected_blocks [$];
    int          send_idle_pct;
    logic        hold_sender;
    int          errors;
    int          cycles;

    threefish512_block_cipher dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .kind(kind), .feed(feed),
        .tweak_lo(tweak_lo), .tweak_hi(tweak_hi),
        .word0(word0), .word1(word1), .word2(word2), .word3(word3),
        .word4(word4), .word5(word5), .word6(word6), .word7(word7),
        .done(done),
        .out_word0(out_word0), .out_word1(out_word1), .out_word2(out_word2),
        .out_word3(out_word3), .out_word4(out_word4), .out_word5(out_word5),
        .out_word6(out_word6), .out_word7(out_word7)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Left and right rotations by the cipher's fixed amounts; reduce modulo 64 for safety
    function automatic word_t rol64(word_t v, int n);
        n = n % 64;
        if (n == 0) return v;
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic word_t ror64(word_t v, int n);
        n = n % 64;
        if (n == 0) return v;
        return (v >> n) | (v << (64 - n));
    endfunction

    // Compute the cipher output for one block under the current key shadow
    function automatic blk_t threefish_predict(block_req_t r);
        int    rot_tab [8][4] = '{'{46, 36, 19, 37}, '{33, 27, 14, 42},
                                 '{17, 49, 36, 39}, '{44, 9, 54, 56},
                                 '{39, 30, 34, 24}, '{13, 50, 10, 17},
                                 '{25, 29, 39, 43}, '{8, 35, 56, 22}};
        int    pair_tab [4][8] = '{'{0, 1, 2, 3, 4, 5, 6, 7},
                                  '{2, 1, 4, 7, 6, 5, 0, 3},
                                  '{4, 1, 6, 3, 0, 5, 2, 7},
                                  '{6, 1, 0, 7, 2, 5, 4, 3}};
        word_t ks [9];
        word_t tw [3];
        word_t v [8];
        word_t inj [8];
        blk_t  res;
        int    a;
        int    b;
        int    s;
        ks[8] = 64'h1BD11BDAA9FC1A22;
        for (int i = 0; i < 8; i++)
        begin
            ks[i] = key_shadow[i];
            ks[8] ^= key_shadow[i];
            v[i] = r.blk[i];
        end
        tw[0] = r.tw_lo;
        tw[1] = r.tw_hi;
        tw[2] = r.tw_lo ^ r.tw_hi;
        if (r.kind == KIND_ENC)
        begin
            for (int d = -1; d < 72; d++)
            begin
                if (d >= 0)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        a = pair_tab[d % 4][2 * j];
                        b = pair_tab[d % 4][2 * j + 1];
                        v[a] = v[a] + v[b];
                        v[b] = rol64(v[b], rot_tab[d % 8][j]) ^ v[a];
                    end
                end
                if (d < 0 || d % 4 == 3)
                begin
                    s = (d + 1) / 4;
                    for (int i = 0; i < 8; i++) inj[i] = ks[(s + i) % 9];
                    inj[5] += tw[s % 3];
                    inj[6] += tw[(s + 1) % 3];
                    inj[7] += word_t'(s);
                    for (int i = 0; i < 8; i++) v[i] = v[i] + inj[i];
                end
            end
            if (r.feed)
                for (int i = 0; i < 8; i++) v[i] ^= r.blk[i];
        end
        else
        begin
            for (int d = 71; d >= -1; d--)
            begin
                if (d < 0 || d % 4 == 3)
                begin
                    s = (d + 1) / 4;
                    for (int i = 0; i < 8; i++) inj[i] = ks[(s + i) % 9];
                    inj[5] += tw[s % 3];
                    inj[6] += tw[(s + 1) % 3];
                    inj[7] += word_t'(s);
                    for (int i = 0; i < 8; i++) v[i] = v[i] - inj[i];
                end
                if (d >= 0)
                begin
                    for (int j = 3; j >= 0; j--)
                    begin
                        a = pair_tab[d % 4][2 * j];
                        b = pair_tab[d % 4][2 * j + 1];
                        v[b] = ror64(v[a] ^ v[b], rot_tab[d % 8][j]);
                        v[a] = v[a] - v[b];
                    end
                end
            end
        end
        for (int i = 0; i < 8; i++) res[i] = v[i];
        return res;
    endfunction

    function automatic word_t rand_word();
        word_t w;
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w = word_t'(1) << $urandom_range(0, 63);
            default: w = {$urandom(), $urandom()};
        endcase
        return w;
    endfunction

    function automatic block_req_t rand_block();
        block_req_t r;
        r.kind  = 1'($urandom_range(0, 1));
        r.feed  = 1'($urandom_range(0, 1));
        r.tw_lo = rand_word();
        r.tw_hi = rand_word();
        for (int i = 0; i < 8; i++) r.blk[i] = rand_word();
        return r;
    endfunction

    // Driver: pop one pending beat per accepted edge, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            kind     <= 1'b0;
            feed     <= 1'b0;
            tweak_lo <= '0;
            tweak_hi <= '0;
            word0 <= '0; word1 <= '0; word2 <= '0; word3 <= '0;
            word4 <= '0; word5 <= '0; word6 <= '0; word7 <= '0;
        end
        else if (!(start && busy))
        begin
            if (pending_blocks.size() != 0 && !hold_sender
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                block_req_t r;
                r = pending_blocks.pop_front();
                expected_blocks.push_back(threefish_predict(r));
                start    <= 1'b1;
                kind     <= r.kind;
                feed     <= r.feed;
                tweak_lo <= r.tw_lo;
                tweak_hi <= r.tw_hi;
                word0 <= r.blk[0]; word1 <= r.blk[1];
                word2 <= r.blk[2]; word3 <= r.blk[3];
                word4 <= r.blk[4]; word5 <= r.blk[5];
                word6 <= r.blk[6]; word7 <= r.blk[7];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            blk_t got;
            blk_t want;
            got = {out_word7, out_word6, out_word5, out_word4,
                   out_word3, out_word2, out_word1, out_word0};
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got[i] !== want[i])
                    begin
                        $display("%0t: out_word%0d expected %h actual %h",
                                 $time, i, want[i], got[i]);
                        errors++;
                    end
            end
        end
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleCap)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write one key register through the configuration port; block must be idle
    task automatic key_write(int idx, word_t val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrKey0 + 6'(8 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < 8) key_shadow[idx] = val;
    endtask

    // Wait for the pipe to drain, then let the trailing latency pass
    task automatic drain();
        while (pending_blocks.size() != 0 || start || expected_blocks.size() != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    task automatic load_key(word_t base, int mode);
        for (int i = 0; i < 8; i++)
            case (mode)
                0: key_write(i, base);
                1: key_write(i, {$urandom(), $urandom()});
                default: key_write(i, base ^ word_t'(i));
            endcase
    endtask

    initial
    begin
        block_req_t r;
        errors = 0;
        cycles = 0;
        send_idle_pct = 25;
        hold_sender = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < 8; i++) key_shadow[i] = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all-zero key from reset, extreme blocks and tweaks, both directions,
        // feed-forward on encrypt and the ignored feed on decrypt
        for (int k = 0; k < 2; k++)
            for (int f = 0; f < 2; f++)
            begin
                r.kind = 1'(k); r.feed = 1'(f);
                r.tw_lo = '0; r.tw_hi = '0; r.blk = '0;
                pending_blocks.push_back(r);
                r.tw_lo = '1; r.tw_hi = '1; r.blk = '1;
                pending_blocks.push_back(r);
                r.tw_lo = 64'h0706050403020100; r.tw_hi = 64'h0F0E0D0C0B0A0908;
                for (int i = 0; i < 8; i++) r.blk[i] = 64'hFFFFFFFFFFFFFFFF - i;
                pending_blocks.push_back(r);
            end
        drain();

        // All-ones key
        load_key('1, 0);
        for (int i = 0; i < 12; i++) pending_blocks.push_back(rand_block());
        drain();

        // Phase 1: sender idles a quarter of the time, random key
        load_key('0, 1);
        for (int i = 0; i < 350; i++) pending_blocks.push_back(rand_block());
        while (pending_blocks.size() > 175) @(posedge clk);
        // Hold off until everything in flight has come back
        hold_sender = 1'b1;
        while (start || expected_blocks.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
        drain();

        // Phase 2: sender idles most of the time, patterned key
        send_idle_pct = 85;
        load_key(64'h0123456789ABCDEF, 2);
        for (int i = 0; i < 350; i++) pending_blocks.push_back(rand_block());
        drain();

        // Phase 3: back to back, zero key then random key
        send_idle_pct = 0;
        load_key('0, 0);
        for (int i = 0; i < 150; i++) pending_blocks.push_back(rand_block());
        drain();
        load_key('0, 1);
        for (int i = 0; i < 200; i++) pending_blocks.push_back(rand_block());
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
